FILE: design/i2c_write_master_top_macros.svh
// ------------------------------------------------------------------------
// I2C write master assertion macros
// Shared concurrent-check wrappers, clocked on clk, off during reset.
// ------------------------------------------------------------------------
`ifndef I2C_WRITE_MASTER_TOP_MACROS_SVH
`define I2C_WRITE_MASTER_TOP_MACROS_SVH

// same-cycle implication
`define IWM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IWM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/iwm_pkg.sv
// ------------------------------------------------------------------------
// iwm_pkg
// Types and constants for the I2C write master.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package iwm_pkg;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_WRITE = 2'd2,
		OP_STOP  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_START_POLL = 4'd1,
		PH_START_HIGH = 4'd2,
		PH_START_HOLD = 4'd3,
		PH_LOW        = 4'd4,
		PH_POLL       = 4'd5,
		PH_HIGH       = 4'd6,
		PH_ACK_LOW    = 4'd7,
		PH_STOP_LOW   = 4'd8,
		PH_STOP_POLL  = 4'd9,
		PH_STOP_HIGH  = 4'd10,
		PH_STOP_END   = 4'd11
	} phase_t;

	// status codes
	localparam logic [2:0] ST_NONE    = 3'd0;
	localparam logic [2:0] ST_ACK     = 3'd1;
	localparam logic [2:0] ST_NACK    = 3'd2;
	localparam logic [2:0] ST_TIMEOUT = 3'd3;
	localparam logic [2:0] ST_BUSY    = 3'd4;

	// bit counter codes
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;
	localparam logic [3:0] ACK_SEEN      = 4'd9;
	localparam logic [3:0] NACK_SEEN     = 4'd10;

	// register indexes
	localparam logic [1:0] CFG_HALF_BIT  = 2'd0;
	localparam logic [1:0] CFG_STRETCH   = 2'd1;
	localparam logic [1:0] CFG_DEV_ADDR  = 2'd2;

	localparam logic [7:0] HALF_BIT_RST  = 8'd5;
	localparam logic [7:0] STRETCH_RST   = 8'd100;
	localparam logic [6:0] DEV_ADDR_RST  = 7'd60;

	// effective configuration (zero counts already forced to one)
	typedef struct packed {
		logic [7:0] half_bit;
		logic [7:0] stretch;
		logic [6:0] dev_addr;
	} cfg_t;

	// one result item, msb first
	typedef struct packed {
		logic       rejected;
		logic [2:0] status;
		logic       done_res;
		logic       busy_res;
		logic       sda_drive;
		logic       scl_drive;
	} res_t;

endpackage

FILE: design/iwm_cfg.sv
// ------------------------------------------------------------------------
// iwm_cfg
// Configuration registers, zero counts forced to one.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module iwm_cfg import iwm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata,
	output cfg_t       cfg
);

	logic [7:0] half_bit_q;
	logic [7:0] stretch_q;
	logic [6:0] dev_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_bit_q <= HALF_BIT_RST;
			stretch_q  <= STRETCH_RST;
			dev_addr_q <= DEV_ADDR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HALF_BIT: half_bit_q <= cfg_wdata;
				CFG_STRETCH:  stretch_q  <= cfg_wdata;
				CFG_DEV_ADDR: dev_addr_q <= cfg_wdata[6:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		cfg.half_bit = (half_bit_q == 8'd0) ? 8'd1 : half_bit_q;
		cfg.stretch  = (stretch_q == 8'd0) ? 8'd1 : stretch_q;
		cfg.dev_addr = dev_addr_q;
	end

endmodule

FILE: design/iwm_fsm.sv
// ------------------------------------------------------------------------
// iwm_fsm
// Bit-level I2C state machine; one step per item.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_write_master_top_macros.svh"

module iwm_fsm import iwm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_en,
	input  op_t        op,
	input  logic [7:0] data_byte,
	input  logic       scl_in,
	input  logic       sda_in,
	input  cfg_t       cfg,
	output res_t       res
);

	phase_t     phase_q, phase_d;
	logic [3:0] bit_q, bit_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] pbyte_q, pbyte_d;
	logic       pvalid_q, pvalid_d;
	logic [7:0] wait_q, wait_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	logic       done;
	logic [2:0] status;
	logic       rej;

	logic [7:0] wait_dec, wait_inc;
	logic       dly_done, poll_out;

	assign wait_dec = (wait_q != 8'd0) ? wait_q - 8'd1 : 8'd0;
	assign dly_done = (wait_dec == 8'd0);
	assign wait_inc = wait_q + 8'd1;
	assign poll_out = (wait_inc >= cfg.stretch);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (op == OP_TICK) begin
			unique case (phase_q)
				PH_START_POLL: begin
					if (scl_in) phase_d = PH_START_HIGH;
					else if (poll_out) phase_d = PH_IDLE;
				end
				PH_START_HIGH: begin
					if (dly_done) phase_d = sda_in ? PH_START_HOLD : PH_IDLE;
				end
				PH_START_HOLD: if (dly_done) phase_d = PH_LOW;
				PH_LOW:        if (dly_done) phase_d = PH_POLL;
				PH_POLL: begin
					if (scl_in) phase_d = PH_HIGH;
					else if (poll_out) phase_d = PH_IDLE;
				end
				PH_HIGH: begin
					if (dly_done) phase_d = (bit_q < BITS_PER_BYTE) ? PH_LOW : PH_ACK_LOW;
				end
				PH_ACK_LOW: begin
					if (dly_done)
						phase_d = (bit_q == ACK_SEEN && pvalid_q) ? PH_LOW : PH_IDLE;
				end
				PH_STOP_LOW: if (dly_done) phase_d = PH_STOP_POLL;
				PH_STOP_POLL: begin
					if (scl_in) phase_d = PH_STOP_HIGH;
					else if (poll_out) phase_d = PH_STOP_END;
				end
				PH_STOP_HIGH: if (dly_done) phase_d = PH_STOP_END;
				PH_STOP_END:  if (dly_done) phase_d = PH_IDLE;
				default:      phase_d = PH_IDLE;
			endcase
		end else if (phase_q == PH_IDLE) begin
			unique case (op)
				OP_START: phase_d = PH_START_POLL;
				OP_WRITE: phase_d = PH_LOW;
				OP_STOP:  phase_d = PH_STOP_LOW;
				default:  phase_d = PH_IDLE;
			endcase
		end
	end

	// datapath and result
	always_comb begin
		bit_d    = bit_q;
		shift_d  = shift_q;
		pbyte_d  = pbyte_q;
		pvalid_d = pvalid_q;
		wait_d   = wait_q;
		scl_d    = scl_q;
		sda_d    = sda_q;
		done     = 1'b0;
		status   = ST_NONE;
		rej      = 1'b0;
		if (op == OP_TICK) begin
			unique case (phase_q)
				PH_START_POLL, PH_POLL: begin
					if (scl_in) wait_d = cfg.half_bit;
					else begin
						wait_d = wait_inc;
						if (poll_out) begin
							pvalid_d = 1'b0;
							wait_d   = 8'd0;
							done     = 1'b1;
							status   = ST_TIMEOUT;
						end
					end
				end
				PH_START_HIGH: begin
					wait_d = wait_dec;
					if (dly_done) begin
						if (!sda_in) begin
							pvalid_d = 1'b0;
							wait_d   = 8'd0;
							done     = 1'b1;
							status   = ST_BUSY;
						end else begin
							sda_d  = 1'b0;
							wait_d = cfg.half_bit;
						end
					end
				end
				PH_START_HOLD: begin
					wait_d = wait_dec;
					if (dly_done) begin
						shift_d = {cfg.dev_addr, 1'b0};
						bit_d   = 4'd0;
						scl_d   = 1'b0;
						wait_d  = cfg.half_bit;
					end
				end
				PH_LOW: begin
					wait_d = wait_dec;
					if (dly_done) begin
						sda_d  = (bit_q < BITS_PER_BYTE) ? shift_q[7] : 1'b1;
						scl_d  = 1'b1;
						wait_d = 8'd0;
					end
				end
				PH_HIGH: begin
					wait_d = wait_dec;
					if (dly_done) begin
						scl_d  = 1'b0;
						wait_d = cfg.half_bit;
						if (bit_q < BITS_PER_BYTE) begin
							shift_d = {shift_q[6:0], 1'b0};
							bit_d   = bit_q + 4'd1;
						end else begin
							bit_d = sda_in ? NACK_SEEN : ACK_SEEN;
						end
					end
				end
				PH_ACK_LOW: begin
					wait_d = wait_dec;
					if (dly_done) begin
						if (bit_q == ACK_SEEN && pvalid_q) begin
							shift_d  = pbyte_q;
							pvalid_d = 1'b0;
							bit_d    = 4'd0;
							scl_d    = 1'b0;
							wait_d   = cfg.half_bit;
						end else begin
							pvalid_d = 1'b0;
							wait_d   = 8'd0;
							done     = 1'b1;
							status   = (bit_q == ACK_SEEN) ? ST_ACK : ST_NACK;
						end
					end
				end
				PH_STOP_LOW: begin
					wait_d = wait_dec;
					if (dly_done) begin
						sda_d  = 1'b0;
						scl_d  = 1'b1;
						wait_d = 8'd0;
					end
				end
				PH_STOP_POLL: begin
					if (scl_in) wait_d = cfg.half_bit;
					else if (poll_out) begin
						// stop finishes even if the clock stays held
						sda_d  = 1'b1;
						wait_d = cfg.half_bit;
					end else wait_d = wait_inc;
				end
				PH_STOP_HIGH: begin
					wait_d = wait_dec;
					if (dly_done) begin
						sda_d  = 1'b1;
						wait_d = cfg.half_bit;
					end
				end
				PH_STOP_END: begin
					wait_d = wait_dec;
					if (dly_done) begin
						pvalid_d = 1'b0;
						wait_d   = 8'd0;
						done     = 1'b1;
						status   = ST_NONE;
					end
				end
				default: ;
			endcase
		end else if (phase_q != PH_IDLE) begin
			rej = 1'b1;
		end else begin
			unique case (op)
				OP_START: begin
					sda_d    = 1'b1;
					scl_d    = 1'b1;
					pbyte_d  = data_byte;
					pvalid_d = 1'b1;
					wait_d   = 8'd0;
				end
				OP_WRITE: begin
					shift_d  = data_byte;
					bit_d    = 4'd0;
					pvalid_d = 1'b0;
					scl_d    = 1'b0;
					wait_d   = cfg.half_bit;
				end
				OP_STOP: begin
					scl_d  = 1'b0;
					wait_d = cfg.half_bit;
				end
				default: ;
			endcase
		end

		res.scl_drive = scl_d;
		res.sda_drive = sda_d;
		res.busy_res  = (phase_d != PH_IDLE);
		res.done_res  = done;
		res.status    = status;
		res.rejected  = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			bit_q    <= 4'd0;
			shift_q  <= 8'd0;
			pbyte_q  <= 8'd0;
			pvalid_q <= 1'b0;
			wait_q   <= 8'd0;
			scl_q    <= 1'b1;
			sda_q    <= 1'b1;
		end else if (item_en) begin
			phase_q  <= phase_d;
			bit_q    <= bit_d;
			shift_q  <= shift_d;
			pbyte_q  <= pbyte_d;
			pvalid_q <= pvalid_d;
			wait_q   <= wait_d;
			scl_q    <= scl_d;
			sda_q    <= sda_d;
		end
	end

	`IWM_ASSERT_NOW(a_status_needs_done, item_en && res.status != ST_NONE, res.done_res, "status without done")
	`IWM_ASSERT_NEXT(a_reject_holds_phase, item_en && res.rejected, phase_q == $past(phase_q), "rejected command moved the phase")
	`IWM_ASSERT_NEXT(a_finish_to_idle, item_en && res.done_res, phase_q == PH_IDLE && !pvalid_q, "finish did not return to idle")
	`IWM_ASSERT_NOW(a_bit_count_range, 1'b1, bit_q <= NACK_SEEN, "bit counter out of range")

endmodule

FILE: design/i2c_write_master_top.sv
// ------------------------------------------------------------------------
// i2c_write_master_top
// Write-only open-drain I2C master with bounded clock stretching.
// ------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_axis. tuser is the operation (tick, start,
//   write, stop); tdata carries the data byte and the sampled SCL/SDA
//   levels. Ticks (one per microsecond) step the bus machine; commands
//   are only taken while idle, else they come back flagged rejected.
//   Every input item yields exactly one result item on m_axis: the SCL
//   and SDA drive levels (0 pulls low), busy, done and a status code.
//   Path: an accepted item enters the input register, then the state
//   step lands in the result register together with the machine state.
//   Throughput: one item per cycle while m_axis_tready is high, set by
//   the single state step between the two registers.
//   Stall: the result register holds while m_axis_tready is low; the
//   input register then fills and s_axis_tready drops, no item lost.
//   Reset: lines released, machine idle, registers back to 5 ticks per
//   half bit, 100 stretch polls, device address 60. Config writes use
//   the cfg port only while the block is idle; user duty, not enforced.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_write_master_top import iwm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // data_byte[7:0], scl_in[8], sda_in[9], zero fill
	input  logic [1:0]  s_axis_tuser,  // operation[1:0]
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // scl_drive[0], sda_drive[1], busy_res[2],
	                                   // done_res[3], status[6:4], rejected[7]
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata
);

	// input register
	logic       valid_s1;
	op_t        op_s1;
	logic [7:0] data_s1;
	logic       scl_s1;
	logic       sda_s1;

	// result register
	logic       out_valid_q;
	logic [7:0] out_data_q;

	logic       advance;
	cfg_t       cfg;
	res_t       res;

	// the item in s1 steps the machine when the result slot is free or draining
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= op_t'(s_axis_tuser);
			data_s1 <= s_axis_tdata[7:0];
			scl_s1  <= s_axis_tdata[8];
			sda_s1  <= s_axis_tdata[9];
		end
	end

	iwm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	iwm_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_en   (advance),
		.op        (op_s1),
		.data_byte (data_s1),
		.scl_in    (scl_s1),
		.sda_in    (sda_s1),
		.cfg       (cfg),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {res.rejected, res.status, res.done_res, res.busy_res,
				res.sda_drive, res.scl_drive};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C write master. Items go in on s_axis and
// each one is run through a bit-level model of the master kept in the
// bench; the result item it predicts is queued and matched, field by
// field, against what comes back on m_axis. A short table of hand-picked
// items comes first, then bus-like random traffic under several register
// settings, with gaps and back-pressure on both sides.
// ------------------------------------------------------------------------

module tb_top;
	import iwm_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;   // data_byte[7:0], scl_in[8], sda_in[9], zero fill
	logic [1:0]  s_axis_tuser = '0;   // operation[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // scl_drive[0], sda_drive[1], busy_res[2],
	                                  // done_res[3], status[6:4], rejected[7]
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_wdata = '0;

	i2c_write_master_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Bench copy of the master: registers as written, machine state
	// ------------------------------------------------------------------
	logic [7:0] half_q    = HALF_BIT_RST;
	logic [7:0] stretch_q = STRETCH_RST;
	logic [6:0] addr_q    = DEV_ADDR_RST;

	phase_t     ph      = PH_IDLE;
	logic [3:0] bit_cnt = '0;
	logic [7:0] shf     = '0;
	logic [7:0] pend    = '0;
	logic       pend_v  = 1'b0;
	logic [7:0] wcnt    = '0;
	logic       scl_q   = 1'b1;
	logic       sda_q   = 1'b1;

	res_t bus_results_q[$];   // results still owed by the block, oldest first
	int unsigned errors = 0;
	int unsigned cyc = 0;

	// bus behaviour knobs for the random traffic
	int unsigned stretch_pct = 20;   // chance a released SCL still reads low
	logic        clk_held = 1'b0;    // target holds SCL low for a whole command
	logic        steady_send = 1'b0; // sender never idles while set

	// one half-bit tick gone; true once the hold has run out
	function automatic logic half_bit_elapsed();
		if (wcnt != 8'd0)
			wcnt = wcnt - 8'd1;
		return wcnt == 8'd0;
	endfunction

	// one more SCL poll seen low; true once the limit is used up
	function automatic logic polls_spent(input logic [7:0] lim);
		wcnt = wcnt + 8'd1;
		return wcnt >= lim;
	endfunction

	function automatic res_t master_step(input op_t op, input logic [7:0] d,
	                                     input logic si, input logic di);
		logic       fin;
		logic [2:0] st;
		logic       rej;
		logic [7:0] hb;
		logic [7:0] lim;
		res_t       r;
		fin = 1'b0;
		st  = ST_NONE;
		rej = 1'b0;
		// a zero count behaves as one
		hb  = (half_q == 8'd0) ? 8'd1 : half_q;
		lim = (stretch_q == 8'd0) ? 8'd1 : stretch_q;

		if (op == OP_TICK) begin
			case (ph)
				PH_IDLE: ;
				PH_START_POLL: begin
					if (si) begin
						wcnt = hb;
						ph = PH_START_HIGH;
					end else if (polls_spent(lim)) begin
						fin = 1'b1;
						st = ST_TIMEOUT;
					end
				end
				PH_START_HIGH: begin
					if (half_bit_elapsed()) begin
						// bus must be free: SDA high before the start edge
						if (!di) begin
							fin = 1'b1;
							st = ST_BUSY;
						end else begin
							sda_q = 1'b0;
							wcnt = hb;
							ph = PH_START_HOLD;
						end
					end
				end
				PH_START_HOLD: begin
					if (half_bit_elapsed()) begin
						shf = {addr_q, 1'b0};
						bit_cnt = '0;
						scl_q = 1'b0;
						wcnt = hb;
						ph = PH_LOW;
					end
				end
				PH_LOW: begin
					if (half_bit_elapsed()) begin
						sda_q = (bit_cnt < BITS_PER_BYTE) ? shf[7] : 1'b1;
						scl_q = 1'b1;
						wcnt = '0;
						ph = PH_POLL;
					end
				end
				PH_POLL: begin
					if (si) begin
						wcnt = hb;
						ph = PH_HIGH;
					end else if (polls_spent(lim)) begin
						fin = 1'b1;
						st = ST_TIMEOUT;
					end
				end
				PH_HIGH: begin
					if (half_bit_elapsed()) begin
						if (bit_cnt < BITS_PER_BYTE) begin
							shf = shf << 1;
							bit_cnt = bit_cnt + 4'd1;
						end else begin
							// ninth clock: SDA is the ACK
							bit_cnt = di ? NACK_SEEN : ACK_SEEN;
						end
						scl_q = 1'b0;
						wcnt = hb;
						ph = (bit_cnt == ACK_SEEN || bit_cnt == NACK_SEEN) ?
							PH_ACK_LOW : PH_LOW;
					end
				end
				PH_ACK_LOW: begin
					if (half_bit_elapsed()) begin
						if (bit_cnt != ACK_SEEN) begin
							fin = 1'b1;
							st = ST_NACK;
						end else if (pend_v) begin
							// control byte follows the address
							shf = pend;
							pend_v = 1'b0;
							bit_cnt = '0;
							scl_q = 1'b0;
							wcnt = hb;
							ph = PH_LOW;
						end else begin
							fin = 1'b1;
							st = ST_ACK;
						end
					end
				end
				PH_STOP_LOW: begin
					if (half_bit_elapsed()) begin
						sda_q = 1'b0;
						scl_q = 1'b1;
						wcnt = '0;
						ph = PH_STOP_POLL;
					end
				end
				PH_STOP_POLL: begin
					if (si) begin
						wcnt = hb;
						ph = PH_STOP_HIGH;
					end else if (polls_spent(lim)) begin
						// stop shrugs off its own timeout
						sda_q = 1'b1;
						wcnt = hb;
						ph = PH_STOP_END;
					end
				end
				PH_STOP_HIGH: begin
					if (half_bit_elapsed()) begin
						sda_q = 1'b1;
						wcnt = hb;
						ph = PH_STOP_END;
					end
				end
				PH_STOP_END: begin
					if (half_bit_elapsed()) begin
						fin = 1'b1;
						st = ST_NONE;
					end
				end
				default: ph = PH_IDLE;
			endcase
			if (fin) begin
				ph = PH_IDLE;
				pend_v = 1'b0;
				wcnt = '0;
			end
		end else if (ph != PH_IDLE) begin
			rej = 1'b1;
		end else begin
			case (op)
				OP_START: begin
					sda_q = 1'b1;
					scl_q = 1'b1;
					pend = d;
					pend_v = 1'b1;
					wcnt = '0;
					ph = PH_START_POLL;
				end
				OP_WRITE: begin
					shf = d;
					bit_cnt = '0;
					pend_v = 1'b0;
					scl_q = 1'b0;
					wcnt = hb;
					ph = PH_LOW;
				end
				default: begin
					scl_q = 1'b0;
					wcnt = hb;
					ph = PH_STOP_LOW;
				end
			endcase
		end

		r.scl_drive = scl_q;
		r.sda_drive = sda_q;
		r.busy_res  = (ph != PH_IDLE);
		r.done_res  = fin;
		r.status    = st;
		r.rejected  = rej;
		return r;
	endfunction

	function automatic res_t lines(input logic scl, input logic sda, input logic busy,
	                               input logic done, input logic [2:0] st,
	                               input logic rej);
		res_t r;
		r.scl_drive = scl;
		r.sda_drive = sda;
		r.busy_res  = busy;
		r.done_res  = done;
		r.status    = st;
		r.rejected  = rej;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------
	// Offers one item, holds it until taken, then steps the bench model.
	// A typed expectation, where given, stands in for the model's.
	task automatic send_item(input op_t op, input logic [7:0] data, input logic si,
	                         input logic di, input logic typed, input res_t want);
		res_t r;
		while (!steady_send && $urandom_range(99) < 13) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {6'b0, di, si, data};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		r = master_step(op, data, si, di);
		bus_results_q.push_back(typed ? want : r);
	endtask

	// Tick carrying line levels roughly as a live bus would show them
	task automatic send_tick();
		logic si;
		logic di;
		if (clk_held)
			si = 1'b0;
		else if (scl_q)
			si = ($urandom_range(99) >= stretch_pct);
		else
			si = ($urandom_range(99) < 5);   // stray high on a pulled-low line
		if (ph == PH_HIGH && bit_cnt == BITS_PER_BYTE)
			di = ($urandom_range(99) < 12);  // mostly ACK
		else if (ph == PH_START_HIGH)
			di = ($urandom_range(99) >= 8);  // mostly a free bus
		else
			di = 1'($urandom_range(1));
		send_item(OP_TICK, 8'($urandom_range(255)), si, di, 1'b0, '0);
	endtask

	// Random commands and ticks, then ticks until the machine is idle
	task automatic run_traffic(input int unsigned count);
		int unsigned n;
		int unsigned pick;
		for (n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (ph == PH_IDLE) begin
				if (pick < 85) begin
					clk_held = ($urandom_range(99) < 6);
					send_item(pick < 40 ? OP_START : (pick < 60 ? OP_WRITE : OP_STOP),
						8'($urandom_range(255)), 1'($urandom_range(1)),
						1'($urandom_range(1)), 1'b0, '0);
				end else
					send_tick();
			end else if (pick < 4)
				// command while busy, must be turned away
				send_item(op_t'($urandom_range(3, 1)), 8'($urandom_range(255)),
					1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
			else
				send_tick();
		end
		clk_held = 1'b0;
		while (ph != PH_IDLE)
			send_tick();
	endtask

	// Sender stops and waits out every owed result plus the pipeline
	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		while (bus_results_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		hold_until_drained();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_HALF_BIT: half_q = val;
			CFG_STRETCH:  stretch_q = val;
			CFG_DEV_ADDR: addr_q = val[6:0];
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// Directed table
	// ------------------------------------------------------------------
	typedef struct {
		logic       is_cfg;
		logic [1:0] idx;
		logic [7:0] val;
		op_t        op;
		logic [7:0] data;
		logic       si;
		logic       di;
		int         reps;
		logic       typed;
		res_t       want;
	} row_t;

	row_t plan[$];

	task automatic add_row(input op_t op, input logic [7:0] data, input logic si,
	                       input logic di, input int reps);
		row_t r;
		r = '{1'b0, '0, '0, op, data, si, di, reps, 1'b0, '0};
		plan.push_back(r);
	endtask

	task automatic add_known(input op_t op, input logic [7:0] data, input logic si,
	                         input logic di, input res_t want);
		row_t r;
		r = '{1'b0, '0, '0, op, data, si, di, 1, 1'b1, want};
		plan.push_back(r);
	endtask

	task automatic add_cfg(input logic [1:0] idx, input logic [7:0] val);
		row_t r;
		r = '{1'b1, idx, val, OP_TICK, '0, 1'b0, 1'b0, 0, 1'b0, '0};
		plan.push_back(r);
	endtask

	initial begin
		// registers at reset values: idle tick, refused command, busy bus
		add_known(OP_TICK, 8'h00, 1'b0, 1'b0, lines(1, 1, 0, 0, ST_NONE, 0));
		add_known(OP_START, 8'hFF, 1'b1, 1'b1, lines(1, 1, 1, 0, ST_NONE, 0));
		add_known(OP_STOP, 8'hFF, 1'b1, 1'b1, lines(1, 1, 1, 0, ST_NONE, 1));
		add_row(OP_TICK, 8'h00, 1'b1, 1'b1, 1);
		add_row(OP_TICK, 8'h00, 1'b1, 1'b0, 4);
		add_known(OP_TICK, 8'h00, 1'b1, 1'b0, lines(1, 1, 0, 1, ST_BUSY, 0));
		// zero counts behave as one
		add_cfg(CFG_HALF_BIT, 8'd0);
		add_cfg(CFG_STRETCH, 8'd0);
		// stop runs on through its own stretch timeout
		add_known(OP_STOP, 8'h00, 1'b0, 1'b0, lines(0, 1, 1, 0, ST_NONE, 0));
		add_row(OP_TICK, 8'h00, 1'b1, 1'b1, 1);
		add_row(OP_TICK, 8'h00, 1'b0, 1'b1, 1);
		add_known(OP_TICK, 8'h00, 1'b0, 1'b0, lines(1, 1, 0, 1, ST_NONE, 0));
		// start with SCL held low
		add_row(OP_START, 8'h00, 1'b0, 1'b0, 1);
		add_known(OP_TICK, 8'h00, 1'b0, 1'b0, lines(1, 1, 0, 1, ST_TIMEOUT, 0));
		// write with no start before it, then a refused write
		add_row(OP_WRITE, 8'hFF, 1'b1, 1'b1, 1);
		add_row(OP_WRITE, 8'h00, 1'b0, 1'b0, 1);
		add_row(OP_TICK, 8'hFF, 1'b1, 1'b1, 1);
		add_known(OP_TICK, 8'hFF, 1'b0, 1'b1, lines(1, 1, 0, 1, ST_TIMEOUT, 0));
		// top address, first address bit then a stretch timeout
		add_cfg(CFG_DEV_ADDR, 8'd127);
		add_row(OP_START, 8'h80, 1'b1, 1'b1, 1);
		add_row(OP_TICK, 8'h00, 1'b1, 1'b1, 4);
		add_known(OP_TICK, 8'h00, 1'b0, 1'b0, lines(1, 1, 0, 1, ST_TIMEOUT, 0));
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_reg(plan[i].idx, plan[i].val);
			else
				repeat (plan[i].reps)
					send_item(plan[i].op, plan[i].data, plan[i].si, plan[i].di,
						plan[i].typed, plan[i].want);
		end

		// nominal timing, the first stretch with no sender gaps
		write_reg(CFG_HALF_BIT, HALF_BIT_RST);
		write_reg(CFG_STRETCH, STRETCH_RST);
		write_reg(CFG_DEV_ADDR, {1'b0, DEV_ADDR_RST});
		steady_send = 1'b1;
		run_traffic(120);
		steady_send = 1'b0;
		run_traffic(120);

		// shortest holds and a single poll: timeouts dominate
		write_reg(CFG_HALF_BIT, 8'd1);
		write_reg(CFG_STRETCH, 8'd1);
		write_reg(CFG_DEV_ADDR, 8'd127);
		stretch_pct = 10;
		run_traffic(140);

		// long holds, top stretch limit: one stop only, a couple of hundred ticks
		write_reg(CFG_HALF_BIT, 8'd85);
		write_reg(CFG_STRETCH, 8'd255);
		write_reg(CFG_DEV_ADDR, 8'd0);
		stretch_pct = 30;
		send_item(OP_STOP, 8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, '0);
		run_traffic(0);

		// random small settings
		write_reg(CFG_HALF_BIT, 8'($urandom_range(4, 1)));
		write_reg(CFG_STRETCH, 8'($urandom_range(20, 2)));
		write_reg(CFG_DEV_ADDR, 8'($urandom_range(127)));
		stretch_pct = 25;
		run_traffic(120);

		write_reg(CFG_HALF_BIT, 8'd2);
		write_reg(CFG_STRETCH, 8'd3);
		write_reg(CFG_DEV_ADDR, 8'h55);
		stretch_pct = 35;
		run_traffic(110);

		s_axis_tvalid <= 1'b0;
		while (bus_results_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	// ------------------------------------------------------------------
	// Result side: random back-pressure, quiet window, checking
	// ------------------------------------------------------------------
	always @(posedge clk)
		cyc <= cyc + 1;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else if (cyc >= 400 && cyc < 900)
			m_axis_tready <= 1'b1;
		else
			m_axis_tready <= ($urandom_range(99) >= 13);
	end

	task automatic note_mismatch(input string what, input int got, input int want);
		$display("tb_top: %s got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = res_t'(m_axis_tdata);
			if (bus_results_q.size() == 0)
				note_mismatch("unowed result, tdata", m_axis_tdata, 0);
			else begin
				want = bus_results_q.pop_front();
				if (got.scl_drive !== want.scl_drive)
					note_mismatch("scl_drive", got.scl_drive, want.scl_drive);
				if (got.sda_drive !== want.sda_drive)
					note_mismatch("sda_drive", got.sda_drive, want.sda_drive);
				if (got.busy_res !== want.busy_res)
					note_mismatch("busy_res", got.busy_res, want.busy_res);
				if (got.done_res !== want.done_res)
					note_mismatch("done_res", got.done_res, want.done_res);
				if (got.status !== want.status)
					note_mismatch("status", got.status, want.status);
				if (got.rejected !== want.rejected)
					note_mismatch("rejected", got.rejected, want.rejected);
			end
		end
	end

	// watchdog, far beyond the slowest passing run
	initial begin
		#5000000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule

FILE: i2c_write_master_top.f
+incdir+design
design/iwm_pkg.sv
design/iwm_cfg.sv
design/iwm_fsm.sv
design/i2c_write_master_top.sv
verif/tb_top.sv
